@@ design/rbe_pkg.sv @@
// Shared types, constants and tables for the range, bearing and arrival-time unit.
`default_nettype none
package rbe_pkg;

    // Root extraction: 33 result digits after a square stage and a sum stage.
    localparam int SQ_DIGITS = 33;
    localparam int SQ_LAT    = SQ_DIGITS + 2;

    // Arrival-time divider: one check stage plus one stage per quotient bit.
    localparam int DIV_BITS = 24;
    localparam int DIV_LAT  = DIV_BITS + 1;

    // CORDIC datapath widths.
    localparam int NORM_W = 41;
    localparam int CX_W   = 45;
    localparam int Z_W    = 32;
    localparam int NORM_STEPS = 6;
    localparam int NORM_SHIFT [NORM_STEPS] = '{32, 16, 8, 4, 2, 1};

    // Angles in 1/65536 hundredth of a degree.
    localparam logic [31:0] ANG_QUARTER   = 32'd589824000;
    localparam logic [31:0] ANG_HALF      = 32'd1179648000;
    localparam logic [31:0] ANG_FULL      = 32'd2359296000;
    localparam logic [31:0] ANG_HALF_HUND = 32'd32768;

    localparam logic [15:0] DEG_FULL      = 16'd36000;
    localparam logic [15:0] BOW_LOW       = 16'd50;
    localparam logic [15:0] BOW_HIGH      = 16'd35950;
    localparam logic [15:0] STERN_LOW     = 16'd17950;
    localparam logic [15:0] STERN_HIGH    = 16'd18050;
    localparam logic [15:0] DEG_HALF      = 16'd18000;

    localparam logic [27:0] RANGE_MAX     = 28'hFFFFFFF;
    localparam logic [23:0] ETA_MAX       = 24'hFFFFFF;
    localparam logic [12:0] YPU_RESET     = 13'd2000;
    localparam logic [5:0]  ETA_SCALE     = 6'd60;
    localparam logic [46:0] RANGE_ROUND   = 47'd32768;

    // atan(2^-i) in 1/65536 hundredth of a degree.
    localparam logic signed [31:0] ATAN_TAB [32] = '{
        32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
        32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
        32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
        32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
        32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
        32'sd358,       32'sd179,       32'sd90,       32'sd45,
        32'sd22,        32'sd11,        32'sd6,        32'sd3,
        32'sd1,         32'sd1,         32'sd0,        32'sd0
    };

    typedef enum logic [1:0] {
        BAND_BOW   = 2'd0,
        BAND_STERN = 2'd1,
        BAND_STBD  = 2'd2,
        BAND_PORT  = 2'd3
    } band_t;

    // Offset quadrant and zero flag, carried beside the CORDIC angle.
    typedef struct packed {
        logic east_neg;
        logic north_neg;
        logic zero;
    } quad_t;

    typedef struct packed {
        logic [15:0] az;
        logic [15:0] rel;
        band_t       band;
    } ang_t;

    typedef struct packed {
        logic [15:0] az;
        logic [15:0] rel;
        logic [27:0] range_yd;
        band_t       band;
        logic [23:0] eta;
        logic        arv;
    } res_t;

endpackage
`default_nettype wire

@@ design/range_bearing_eta_calc_unit.sv @@
// The result path runs through the 33-digit root, the 24-bit arrival divider and the
// alignment delays that follow them. Throughput: one item per cycle while the skid
// is empty; the CORDIC, root and divider are fully pipelined.
// An output register plus a one-entry skid stage; the pipeline halts while the skid is full.
// Reset clears all valid bits and loads yards_per_unit with 2000.
`default_nettype none
module range_bearing_eta_calc_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // own_x, own_y, own_course, own_speed, target_x, target_y
    input  wire logic [167:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // true_azimuth, relative_bearing, range_yards, side_band, arrival_minutes, 2 zero bits
    output logic [87:0]       m_axis_tdata,
    // arrival_valid
    output logic [0:0]        m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic [12:0]  cfg_wdata
);
    import rbe_pkg::*;

    localparam int CORDIC_LAT = CORDIC_STAGES + 3;
    localparam int PIPE_LEN   = 1 + SQ_LAT + 1 + DIV_LAT;
    localparam int ANG_DLY    = SQ_LAT + 1 + DIV_LAT - (CORDIC_LAT + 3);
    localparam int COURSE_DLY = CORDIC_LAT + 2;

    logic              en;
    logic [12:0]       ypu_reg;
    logic [PIPE_LEN-1:0] vld_reg;

    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic [15:0]        course_reg;
    logic [23:0]        speed_reg;
    logic [15:0]        course_in;

    logic [32:0]        root;
    logic signed [Z_W-1:0] z;
    quad_t              quad;

    logic [29:0]        zc;
    logic [31:0]        full_next;
    logic [31:0]        full_reg;
    logic [32:0]        az_sum;
    logic [16:0]        az_raw;
    logic [15:0]        az_reg;
    logic [15:0]        course_d;
    logic [16:0]        rel_wide;
    logic [15:0]        rel;
    band_t              band;
    ang_t               ang_reg;
    ang_t               ang_d;

    logic [23:0]        speed_d;
    logic [45:0]        prod_reg;
    logic [38:0]        num_reg;
    logic [23:0]        den_reg;
    logic               arv_reg;
    logic [45:0]        prod_d;
    logic               arv_d;
    logic [23:0]        quo;
    logic               quo_sat;

    logic [46:0]        range_sum;
    logic [30:0]        range_raw;
    res_t               res_now;
    logic               push;

    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_data_reg;
    res_t               out_data_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    res_t               skid_data_reg;
    res_t               skid_data_next;

    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;
    assign course_in     = (s_axis_tdata[79:64] >= DEG_FULL) ?
                           s_axis_tdata[79:64] - DEG_FULL : s_axis_tdata[79:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ypu_reg <= YPU_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ypu_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_LEN-2:0], s_axis_tvalid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= signed'({s_axis_tdata[135], s_axis_tdata[135:104]})
                        - signed'({s_axis_tdata[31], s_axis_tdata[31:0]});
            dy_reg     <= signed'({s_axis_tdata[167], s_axis_tdata[167:136]})
                        - signed'({s_axis_tdata[63], s_axis_tdata[63:32]});
            course_reg <= course_in;
            speed_reg  <= s_axis_tdata[103:80];
        end
    end

    rbe_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .root (root)
    );

    rbe_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk      (clk),
        .en       (en),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .z_out    (z),
        .quad_out (quad)
    );

    // Clamp the folded angle to a quarter turn and unfold it by quadrant.
    always_comb
    begin
        if (z[Z_W-1])
        begin
            zc = '0;
        end
        else if (z > signed'({1'b0, ANG_QUARTER[30:0]}))
        begin
            zc = ANG_QUARTER[29:0];
        end
        else
        begin
            zc = z[29:0];
        end

        if (quad.zero)
        begin
            full_next = '0;
        end
        else if (!quad.east_neg && !quad.north_neg)
        begin
            full_next = {2'b00, zc};
        end
        else if (!quad.east_neg)
        begin
            full_next = ANG_HALF - {2'b00, zc};
        end
        else if (quad.north_neg)
        begin
            full_next = ANG_HALF + {2'b00, zc};
        end
        else
        begin
            full_next = ANG_FULL - {2'b00, zc};
        end
    end

    assign az_sum = {1'b0, full_reg} + {1'b0, ANG_HALF_HUND};
    assign az_raw = az_sum[32:16];

    rbe_delay #(.WIDTH(16), .DEPTH(COURSE_DLY)) u_course_dly (
        .clk  (clk),
        .en   (en),
        .din  (course_reg),
        .dout (course_d)
    );

    assign rel_wide = (az_reg >= course_d) ? {1'b0, az_reg - course_d}
                    : {1'b0, az_reg} + {1'b0, DEG_FULL} - {1'b0, course_d};
    assign rel      = rel_wide[15:0];

    always_comb
    begin
        if (rel < BOW_LOW || rel > BOW_HIGH)
        begin
            band = BAND_BOW;
        end
        else if (rel > STERN_LOW && rel < STERN_HIGH)
        begin
            band = BAND_STERN;
        end
        else if (rel < DEG_HALF)
        begin
            band = BAND_STBD;
        end
        else
        begin
            band = BAND_PORT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg     <= full_next;
            az_reg       <= (az_raw >= {1'b0, DEG_FULL}) ?
                            16'(az_raw - {1'b0, DEG_FULL}) : az_raw[15:0];
            ang_reg.az   <= az_reg;
            ang_reg.rel  <= rel;
            ang_reg.band <= band;
        end
    end

    rbe_delay #(.WIDTH($bits(ang_t)), .DEPTH(ANG_DLY)) u_ang_dly (
        .clk  (clk),
        .en   (en),
        .din  (ang_reg),
        .dout (ang_d)
    );

    rbe_delay #(.WIDTH(24), .DEPTH(SQ_LAT)) u_speed_dly (
        .clk  (clk),
        .en   (en),
        .din  (speed_reg),
        .dout (speed_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= root * ypu_reg;
            num_reg  <= 39'(root) * 39'(ETA_SCALE) + 39'(speed_d >> 1);
            den_reg  <= speed_d;
            arv_reg  <= (speed_d != '0) && (root != '0);
        end
    end

    rbe_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo),
        .sat (quo_sat)
    );

    rbe_delay #(.WIDTH(47), .DEPTH(DIV_LAT)) u_side_dly (
        .clk  (clk),
        .en   (en),
        .din  ({prod_reg, arv_reg}),
        .dout ({prod_d, arv_d})
    );

    assign range_sum = {1'b0, prod_d} + RANGE_ROUND;
    assign range_raw = range_sum[46:16];

    always_comb
    begin
        res_now.az       = ang_d.az;
        res_now.rel      = ang_d.rel;
        res_now.band     = ang_d.band;
        res_now.range_yd = (range_raw > {3'b000, RANGE_MAX}) ? RANGE_MAX : range_raw[27:0];
        res_now.arv      = arv_d;
        if (!arv_d)
        begin
            res_now.eta = '0;
        end
        else if (quo_sat)
        begin
            res_now.eta = ETA_MAX;
        end
        else
        begin
            res_now.eta = quo;
        end
    end

    assign push = en & vld_reg[PIPE_LEN-1];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = res_now;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_data_reg.eta, out_data_reg.band,
                            out_data_reg.range_yd, out_data_reg.rel, out_data_reg.az};
    assign m_axis_tuser  = out_data_reg.arv;

    // The skid entry only fills behind a stalled output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid entry filled while the output was free");

    a_eta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.arv) |-> (out_data_reg.eta == '0))
        else $error("arrival time nonzero on an invalid arrival");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.az < DEG_FULL && out_data_reg.rel < DEG_FULL))
        else $error("azimuth or relative bearing out of range");
endmodule
`default_nettype wire

@@ design/rbe_delay.sv @@
// Enable-gated delay line that keeps side data aligned with the long pipeline paths.
`default_nettype none
module rbe_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] d_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

    assign dout = d_reg[DEPTH-1];
endmodule
`default_nettype wire

@@ design/rbe_isqrt.sv @@
// Pipelined exact square root of dx^2 + dy^2, one result digit per stage.
`default_nettype none
module rbe_isqrt (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [32:0] dx,
    input  wire logic signed [32:0] dy,
    output logic             [32:0] root
);
    import rbe_pkg::*;

    logic signed [32:0] ax_s;
    logic signed [32:0] ay_s;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] sa_reg;
    logic [63:0] sb_reg;
    logic [65:0] sum_reg;

    logic [35:0] rem_reg  [SQ_DIGITS];
    logic [32:0] root_reg [SQ_DIGITS];
    logic [65:0] rad_reg  [SQ_DIGITS];

    assign ax_s = dx[32] ? -dx : dx;
    assign ay_s = dy[32] ? -dy : dy;
    assign ax   = ax_s[31:0];
    assign ay   = ay_s[31:0];
    assign sa   = ax * ax;
    assign sb   = ay * ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg  <= sa;
            sb_reg  <= sb;
            sum_reg <= {2'b00, sa_reg} + {2'b00, sb_reg};
        end
    end

    for (genvar k = 0; k < SQ_DIGITS; k++)
    begin : g_digit
        localparam int I = SQ_DIGITS - 1 - k;
        logic [35:0] rem_in;
        logic [32:0] root_in;
        logic [65:0] rad_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = sum_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign rem_sh = {rem_in[33:0], rad_in[2*I+1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k] <= rad_in;
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[31:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[31:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SQ_DIGITS-1];
endmodule
`default_nettype wire

@@ design/rbe_cordic.sv @@
// Folded-quadrant vectoring CORDIC with a staged normalizing shift.
`default_nettype none
module rbe_cordic #(
    parameter int STAGES = 24
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic signed [32:0]     dx,
    input  wire logic signed [32:0]     dy,
    output logic signed [rbe_pkg::Z_W-1:0] z_out,
    output rbe_pkg::quad_t              quad_out
);
    import rbe_pkg::*;

    logic signed [32:0] ax_s;
    logic signed [32:0] ay_s;
    logic [NORM_W-1:0] n_a_reg;
    logic [NORM_W-1:0] e_a_reg;
    quad_t             quad_a_reg;
    logic [NORM_W-1:0] n_b_next;
    logic [NORM_W-1:0] e_b_next;
    logic [NORM_W-1:0] n_b_reg;
    logic [NORM_W-1:0] e_b_reg;
    quad_t             quad_b_reg;
    logic [NORM_W-1:0] n_c_next;
    logic [NORM_W-1:0] e_c_next;

    logic signed [CX_W-1:0] x_reg [STAGES+1];
    logic signed [CX_W-1:0] y_reg [STAGES+1];
    logic signed [Z_W-1:0]  z_reg [STAGES+1];
    quad_t                  quad_reg [STAGES+1];

    assign ax_s = dx[32] ? -dx : dx;
    assign ay_s = dy[32] ? -dy : dy;

    // A nonzero offset is shifted left by 32, 16, 8, then 4, 2, 1 until its larger part reaches 2^40.
    always_comb
    begin
        n_b_next = n_a_reg;
        e_b_next = e_a_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (((n_b_next | e_b_next) >> (NORM_W - NORM_SHIFT[j])) == '0)
            begin
                n_b_next = n_b_next << NORM_SHIFT[j];
                e_b_next = e_b_next << NORM_SHIFT[j];
            end
        end
    end

    always_comb
    begin
        n_c_next = n_b_reg;
        e_c_next = e_b_reg;
        for (int j = 3; j < NORM_STEPS; j++)
        begin
            if (((n_c_next | e_c_next) >> (NORM_W - NORM_SHIFT[j])) == '0)
            begin
                n_c_next = n_c_next << NORM_SHIFT[j];
                e_c_next = e_c_next << NORM_SHIFT[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_a_reg              <= {9'b0, ay_s[31:0]};
            e_a_reg              <= {9'b0, ax_s[31:0]};
            quad_a_reg.east_neg  <= dx[32];
            quad_a_reg.north_neg <= dy[32];
            quad_a_reg.zero      <= (dx == '0) && (dy == '0);
            n_b_reg              <= n_b_next;
            e_b_reg              <= e_b_next;
            quad_b_reg           <= quad_a_reg;
            x_reg[0]             <= signed'({4'b0, n_c_next});
            y_reg[0]             <= signed'({4'b0, e_c_next});
            z_reg[0]             <= '0;
            quad_reg[0]          <= quad_b_reg;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_iter
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;

        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[k+1] <= quad_reg[k];
                if (!y_reg[k][CX_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + ATAN_TAB[k];
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - ATAN_TAB[k];
                end
            end
        end
    end

    assign z_out    = z_reg[STAGES];
    assign quad_out = quad_reg[STAGES];
endmodule
`default_nettype wire

@@ design/rbe_div.sv @@
// Pipelined restoring divider for the arrival time, one quotient bit per stage.
`default_nettype none
module rbe_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [38:0] num,
    input  wire logic [23:0] den,
    output logic      [23:0] quo,
    output logic             sat
);
    import rbe_pkg::*;

    logic [38:0] rem_reg [DIV_BITS+1];
    logic [23:0] den_reg [DIV_BITS+1];
    logic [23:0] q_reg   [DIV_BITS+1];
    logic        sat_reg [DIV_BITS+1];

    // A quotient of 2^24 or more saturates; below that 24 steps suffice.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= {9'b0, num} >= {den, 24'b0};
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_bit
        localparam int B = DIV_BITS - 1 - k;
        logic [47:0] dsh;

        assign dsh = {24'b0, den_reg[k]} << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k+1] <= den_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                if ({9'b0, rem_reg[k]} >= dsh)
                begin
                    rem_reg[k+1] <= 39'({9'b0, rem_reg[k]} - dsh);
                    q_reg[k+1]   <= q_reg[k] | (24'd1 << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    q_reg[k+1]   <= q_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[DIV_BITS];
    assign sat = sat_reg[DIV_BITS];
endmodule
`default_nettype wire
